// ===== rtl/core/mdss_pkg.sv =====
// ============================================================================
// Motor drive safety supervisor package
// Shared item codes, pending check codes, register indexes, error byte codes and register reset values.
// ============================================================================
`default_nettype none

package mdss_pkg;

    // Kind of input item
    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_COMMAND = 2'd1,
        MODE_TEMP    = 2'd2,
        MODE_ERROR   = 2'd3
    } mode_t;

    // Pending temperature check
    typedef enum logic [1:0] {
        TP_NONE = 2'd0,
        TP_HEAT = 2'd1,
        TP_COOL = 2'd2
    } temp_pend_t;

    // Configuration register indexes
    localparam logic [2:0] REG_TEMP_CRITICAL   = 3'd0;
    localparam logic [2:0] REG_TEMP_DROP       = 3'd1;
    localparam logic [2:0] REG_CONFIRM_REPEATS = 3'd2;
    localparam logic [2:0] REG_STOP_TIMEOUT    = 3'd3;
    localparam logic [2:0] REG_RESET_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_RESET_DELAY     = 3'd5;

    // Controller error byte codes
    localparam logic [7:0] ERR_NORMAL         = 8'h00;
    localparam logic [7:0] ERR_M1_OVERCURRENT = 8'h01;
    localparam logic [7:0] ERR_M2_OVERCURRENT = 8'h02;
    localparam logic [7:0] ERR_BATTERY_LOW    = 8'h20;

    // Register reset values
    localparam logic [15:0] TEMP_CRITICAL_RST   = 16'd70;
    localparam logic [15:0] TEMP_DROP_RST       = 16'd60;
    localparam logic [3:0]  CONFIRM_REPEATS_RST = 4'd0;
    localparam logic [15:0] STOP_TIMEOUT_RST    = 16'd1000;
    localparam logic [15:0] RESET_TIMEOUT_RST   = 16'd10000;
    localparam logic [15:0] RESET_DELAY_RST     = 16'd260;

endpackage

`default_nettype wire

// ===== rtl/core/motor_drive_safety_supervisor.sv =====
// ============================================================================
// Motor drive safety supervisor
// Watches ticks, motor commands, temperature pairs and error status pairs
// and decides on motor stops, controller resets and the battery lockout.
// ============================================================================
//
//  Channel  | Signals                                  | Direction
//  ---------+------------------------------------------+----------
//  input    | in_valid/in_ready, mode, readings        | in
//  result   | out_valid/out_ready, six status flags    | out
//  config   | cfg_we, cfg_index, cfg_data              | in
//
//  One item is accepted per cycle while in_ready is high; its result passes
//  through the input register, then the result register, before it is
//  presented on the result channel.
//  The state update is a single pass of compare and count logic.
//  A stalled result register holds the input register, which then holds
//  in_ready low; no transaction is lost or repeated.
//  Reset (rst_n low) returns the config, state and valid registers to their defaults.
`default_nettype none

module motor_drive_safety_supervisor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input item channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] front_reading,
    input  wire logic [15:0] rear_reading,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             stop_motors,
    output logic             reset_request,
    output logic             command_forward,
    output logic             battery_lockout,
    output logic             overheat_flag,
    output logic             drive_disabled,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Configuration registers
    logic [15:0] temp_critical_reg;
    logic [15:0] temp_drop_reg;
    logic [3:0]  confirm_repeats_reg;
    logic [15:0] stop_timeout_reg;
    logic [15:0] reset_timeout_reg;
    logic [15:0] reset_delay_reg;

    // Supervisor state
    logic [15:0]         stop_rem_reg,    stop_rem_next;
    logic                stop_armed_reg,  stop_armed_next;
    logic [15:0]         reset_rem_reg,   reset_rem_next;
    logic [15:0]         disable_rem_reg, disable_rem_next;
    logic                overheated_reg,  overheated_next;
    logic                lockout_reg,     lockout_next;
    mdss_pkg::temp_pend_t temp_pend_reg,  temp_pend_next;
    logic [3:0]          temp_conf_reg,   temp_conf_next;
    logic                err_pend_reg,    err_pend_next;
    logic [3:0]          err_conf_reg,    err_conf_next;
    logic [7:0]          err_front_reg,   err_front_next;
    logic [7:0]          err_rear_reg,    err_rear_next;

    // Input register
    logic                s1_valid_reg;
    mdss_pkg::mode_t     s1_mode_reg;
    logic [15:0]         s1_front_reg;
    logic [15:0]         s1_rear_reg;

    // Result register
    logic out_valid_reg;
    logic stop_reg, reset_req_reg, fwd_reg;
    logic lockout_out_reg, overheat_out_reg, disabled_out_reg;

    // Per-item decisions
    logic       req_stop, req_reset, fwd;
    logic       out_free;
    logic       s1_advance;
    logic [3:0] temp_conf_inc;
    logic [3:0] err_conf_inc;
    logic [7:0] err_f;
    logic [7:0] err_r;
    logic       heat_detect;
    logic       cool_detect;
    logic       overcurrent;
    logic       battery_low;

    // Flow control: the result register frees when empty or taken
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;

    assign temp_conf_inc = temp_conf_reg + 4'd1;
    assign err_conf_inc  = err_conf_reg + 4'd1;
    assign err_f         = s1_front_reg[7:0];
    assign err_r         = s1_rear_reg[7:0];
    assign heat_detect   = (s1_front_reg > temp_critical_reg) ||
                           (s1_rear_reg > temp_critical_reg);
    assign cool_detect   = (s1_front_reg < temp_drop_reg) &&
                           (s1_rear_reg < temp_drop_reg);
    assign overcurrent   = (err_f == mdss_pkg::ERR_M1_OVERCURRENT) ||
                           (err_f == mdss_pkg::ERR_M2_OVERCURRENT) ||
                           (err_r == mdss_pkg::ERR_M1_OVERCURRENT) ||
                           (err_r == mdss_pkg::ERR_M2_OVERCURRENT);
    assign battery_low   = (err_f == mdss_pkg::ERR_BATTERY_LOW) ||
                           (err_r == mdss_pkg::ERR_BATTERY_LOW);

    // Next state and result for the item in the input register
    always_comb
    begin
        stop_rem_next    = stop_rem_reg;
        stop_armed_next  = stop_armed_reg;
        reset_rem_next   = reset_rem_reg;
        disable_rem_next = disable_rem_reg;
        overheated_next  = overheated_reg;
        lockout_next     = lockout_reg;
        temp_pend_next   = temp_pend_reg;
        temp_conf_next   = temp_conf_reg;
        err_pend_next    = err_pend_reg;
        err_conf_next    = err_conf_reg;
        err_front_next   = err_front_reg;
        err_rear_next    = err_rear_reg;
        req_stop         = 1'b0;
        req_reset        = 1'b0;
        fwd              = 1'b0;

        unique case (s1_mode_reg)
            mdss_pkg::MODE_TICK:
            begin
                // The disabled period counts down even under lockout.
                if (disable_rem_reg != 16'd0)
                begin
                    disable_rem_next = disable_rem_reg - 16'd1;
                end
                if (!lockout_reg)
                begin
                    if (stop_armed_reg)
                    begin
                        if (stop_rem_reg[15:1] == 15'd0)
                        begin
                            stop_rem_next   = 16'd0;
                            stop_armed_next = 1'b0;
                            req_stop        = 1'b1;
                        end
                        else
                        begin
                            stop_rem_next = stop_rem_reg - 16'd1;
                        end
                    end
                    if (reset_rem_reg[15:1] == 15'd0)
                    begin
                        reset_rem_next   = reset_timeout_reg;
                        req_reset        = 1'b1;
                        disable_rem_next = reset_delay_reg;
                    end
                    else
                    begin
                        reset_rem_next = reset_rem_reg - 16'd1;
                    end
                end
            end

            mdss_pkg::MODE_COMMAND:
            begin
                // A command re-arms both timers, even while disabled.
                if (!lockout_reg)
                begin
                    stop_rem_next   = stop_timeout_reg;
                    reset_rem_next  = reset_timeout_reg;
                    stop_armed_next = 1'b1;
                    fwd             = (disable_rem_reg == 16'd0);
                end
            end

            mdss_pkg::MODE_TEMP:
            begin
                if (!lockout_reg && disable_rem_reg == 16'd0)
                begin
                    if (temp_pend_reg == mdss_pkg::TP_NONE)
                    begin
                        // Look for a new transition.
                        if ((overheated_reg && cool_detect) ||
                            (!overheated_reg && heat_detect))
                        begin
                            temp_conf_next = 4'd0;
                            if (confirm_repeats_reg != 4'd0)
                            begin
                                temp_pend_next = overheated_reg ? mdss_pkg::TP_COOL
                                                                : mdss_pkg::TP_HEAT;
                            end
                            else if (overheated_reg)
                            begin
                                overheated_next  = 1'b0;
                                req_reset        = 1'b1;
                                disable_rem_next = reset_delay_reg;
                            end
                            else
                            begin
                                overheated_next = 1'b1;
                                req_stop        = 1'b1;
                            end
                        end
                    end
                    else if ((temp_pend_reg == mdss_pkg::TP_HEAT &&
                              s1_front_reg < temp_critical_reg &&
                              s1_rear_reg < temp_critical_reg) ||
                             (temp_pend_reg != mdss_pkg::TP_HEAT &&
                              (s1_front_reg > temp_drop_reg ||
                               s1_rear_reg > temp_drop_reg)))
                    begin
                        // The sample contradicts the pending check.
                        temp_pend_next = mdss_pkg::TP_NONE;
                        temp_conf_next = 4'd0;
                    end
                    else if (temp_conf_inc >= confirm_repeats_reg)
                    begin
                        // Confirmed: complete the transition.
                        temp_pend_next = mdss_pkg::TP_NONE;
                        temp_conf_next = 4'd0;
                        if (temp_pend_reg == mdss_pkg::TP_HEAT)
                        begin
                            overheated_next = 1'b1;
                            req_stop        = 1'b1;
                        end
                        else
                        begin
                            overheated_next  = 1'b0;
                            req_reset        = 1'b1;
                            disable_rem_next = reset_delay_reg;
                        end
                    end
                    else
                    begin
                        temp_conf_next = temp_conf_inc;
                    end
                end
            end

            mdss_pkg::MODE_ERROR:
            begin
                if (!lockout_reg)
                begin
                    if (!err_pend_reg &&
                        (err_f == mdss_pkg::ERR_NORMAL) &&
                        (err_r == mdss_pkg::ERR_NORMAL))
                    begin
                        // Normal status with nothing pending: no action.
                    end
                    else if (err_pend_reg &&
                             (err_f != err_front_reg || err_r != err_rear_reg))
                    begin
                        err_pend_next = 1'b0;
                        err_conf_next = 4'd0;
                    end
                    else if ((!err_pend_reg && confirm_repeats_reg == 4'd0) ||
                             (err_pend_reg && err_conf_inc >= confirm_repeats_reg))
                    begin
                        // Confirmed pair: it equals the saved one, or no confirmation is configured.
                        err_front_next = err_f;
                        err_rear_next  = err_r;
                        err_pend_next  = 1'b0;
                        err_conf_next  = 4'd0;
                        if (overcurrent)
                        begin
                            req_reset        = 1'b1;
                            disable_rem_next = reset_delay_reg;
                        end
                        else if (battery_low)
                        begin
                            lockout_next = 1'b1;
                        end
                    end
                    else if (!err_pend_reg)
                    begin
                        err_front_next = err_f;
                        err_rear_next  = err_r;
                        err_conf_next  = 4'd0;
                        err_pend_next  = 1'b1;
                    end
                    else
                    begin
                        err_conf_next = err_conf_inc;
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_critical_reg   <= mdss_pkg::TEMP_CRITICAL_RST;
            temp_drop_reg       <= mdss_pkg::TEMP_DROP_RST;
            confirm_repeats_reg <= mdss_pkg::CONFIRM_REPEATS_RST;
            stop_timeout_reg    <= mdss_pkg::STOP_TIMEOUT_RST;
            reset_timeout_reg   <= mdss_pkg::RESET_TIMEOUT_RST;
            reset_delay_reg     <= mdss_pkg::RESET_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mdss_pkg::REG_TEMP_CRITICAL:   temp_critical_reg   <= cfg_data;
                mdss_pkg::REG_TEMP_DROP:       temp_drop_reg       <= cfg_data;
                mdss_pkg::REG_CONFIRM_REPEATS: confirm_repeats_reg <= cfg_data[3:0];
                mdss_pkg::REG_STOP_TIMEOUT:    stop_timeout_reg    <= cfg_data;
                mdss_pkg::REG_RESET_TIMEOUT:   reset_timeout_reg   <= cfg_data;
                mdss_pkg::REG_RESET_DELAY:     reset_delay_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Supervisor state, updated as each item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_rem_reg    <= mdss_pkg::STOP_TIMEOUT_RST;
            stop_armed_reg  <= 1'b1;
            reset_rem_reg   <= mdss_pkg::RESET_TIMEOUT_RST;
            disable_rem_reg <= 16'd0;
            overheated_reg  <= 1'b0;
            lockout_reg     <= 1'b0;
            temp_pend_reg   <= mdss_pkg::TP_NONE;
            temp_conf_reg   <= 4'd0;
            err_pend_reg    <= 1'b0;
            err_conf_reg    <= 4'd0;
            err_front_reg   <= 8'd0;
            err_rear_reg    <= 8'd0;
        end
        else if (s1_advance)
        begin
            stop_rem_reg    <= stop_rem_next;
            stop_armed_reg  <= stop_armed_next;
            reset_rem_reg   <= reset_rem_next;
            disable_rem_reg <= disable_rem_next;
            overheated_reg  <= overheated_next;
            lockout_reg     <= lockout_next;
            temp_pend_reg   <= temp_pend_next;
            temp_conf_reg   <= temp_conf_next;
            err_pend_reg    <= err_pend_next;
            err_conf_reg    <= err_conf_next;
            err_front_reg   <= err_front_next;
            err_rear_reg    <= err_rear_next;
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg  <= mdss_pkg::mode_t'(mode);
            s1_front_reg <= front_reading;
            s1_rear_reg  <= rear_reading;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            stop_reg         <= req_stop;
            reset_req_reg    <= req_reset;
            fwd_reg          <= fwd;
            lockout_out_reg  <= lockout_next;
            overheat_out_reg <= overheated_next;
            disabled_out_reg <= (disable_rem_next != 16'd0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign stop_motors     = stop_reg;
    assign reset_request   = reset_req_reg;
    assign command_forward = fwd_reg;
    assign battery_lockout = lockout_out_reg;
    assign overheat_flag   = overheat_out_reg;
    assign drive_disabled  = disabled_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mdss_checker.sv =====
// ============================================================================
// Motor drive safety supervisor checker
// Port-level properties of the supervisor, bound to the top level.
// ============================================================================
`default_nettype none

module mdss_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic stop_motors,
    input wire logic reset_request,
    input wire logic command_forward,
    input wire logic battery_lockout,
    input wire logic overheat_flag,
    input wire logic drive_disabled
);

    // A stalled result transaction holds its flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(stop_motors) &&
            $stable(reset_request) && $stable(command_forward) &&
            $stable(battery_lockout) && $stable(overheat_flag) &&
            $stable(drive_disabled))
        else $error("result changed while stalled");

    // No reset request is issued under the battery lockout.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_request |-> !battery_lockout)
        else $error("reset request under lockout");

    // A forwarded command never coincides with a disabled drive or an action.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_forward |-> !drive_disabled && !stop_motors &&
            !reset_request)
        else $error("command forwarded with conflicting flags");

    // The lockout is latched: a later result keeps it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && battery_lockout |=> !out_valid || battery_lockout)
        else $error("battery lockout cleared without reset");

endmodule

bind motor_drive_safety_supervisor mdss_checker u_mdss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .stop_motors     (stop_motors),
    .reset_request   (reset_request),
    .command_forward (command_forward),
    .battery_lockout (battery_lockout),
    .overheat_flag   (overheat_flag),
    .drive_disabled  (drive_disabled)
);

`default_nettype wire
